@@ rtl/e2r_pkg.sv @@
// Package: shared constants, types and helpers for the Euler angle to rotation matrix block.
package e2r_pkg;

    localparam int ANG_W = 17;
    localparam int OUT_W = 16;
    localparam int Q_W   = 32;   // signed Q30, magnitude up to 2^30 plus a sign bit
    localparam logic [24:0] DEG_TO_RAD_Q30 = 25'd18740330;

    typedef struct packed {
        logic signed [Q_W-1:0] s;
        logic signed [Q_W-1:0] c;
    } sc_t;

    // Q30 x Q30 product, rounded half away from zero
    function automatic logic signed [Q_W-1:0] qmul(input logic signed [Q_W-1:0] a,
                                                  input logic signed [Q_W-1:0] b);
        logic        neg;
        logic [30:0] ua;
        logic [30:0] ub;
        logic [61:0] p;
        logic [31:0] r;
        begin
            neg = a[Q_W-1] ^ b[Q_W-1];
            ua  = a[Q_W-1] ? 31'(-a) : 31'(a);
            ub  = b[Q_W-1] ? 31'(-b) : 31'(b);
            p   = ua * ub + 62'(64'd1 << 29);
            r   = {1'b0, p[60:30]};
            qmul = neg ? -$signed(r) : $signed(r);
        end
    endfunction

endpackage

@@ rtl/e2r_sincos.sv @@
// Sine and cosine of an angle in degrees, pipelined range reduction and series.
module e2r_sincos
    import e2r_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [ANG_W-1:0]  angle,
    output sc_t                      result
);
    localparam int FULL  = 360 << ANGLE_FRAC_BITS;
    localparam int Q90   = 90 << ANGLE_FRAC_BITS;
    localparam int RW    = $clog2(FULL + 1);
    localparam int MW    = ((RW > ANG_W) ? RW : ANG_W) + 2;
    localparam int NWRAP = (1 << (ANG_W - 1)) / FULL + 1;
    localparam int NS    = 6;
    localparam int SK [NS] = '{156, 110, 72, 42, 20, 6};
    localparam int CK [NS] = '{132, 90, 56, 30, 12, 2};

    // floor(n / d) == (n * recip(d)) >> rshift(d) for every n below 2^30
    function automatic int rshift(input int d);
        return 30 + $clog2(d);
    endfunction

    function automatic longint unsigned recip(input int d);
        return ((64'd1 << rshift(d)) + 64'(d) - 64'd1) / 64'(d);
    endfunction

    localparam longint unsigned SM [NS] = '{recip(SK[0]), recip(SK[1]), recip(SK[2]),
                                            recip(SK[3]), recip(SK[4]), recip(SK[5])};
    localparam longint unsigned CM [NS] = '{recip(CK[0]), recip(CK[1]), recip(CK[2]),
                                            recip(CK[3]), recip(CK[4]), recip(CK[5])};
    localparam int SSH [NS] = '{rshift(SK[0]), rshift(SK[1]), rshift(SK[2]),
                                rshift(SK[3]), rshift(SK[4]), rshift(SK[5])};
    localparam int CSH [NS] = '{rshift(CK[0]), rshift(CK[1]), rshift(CK[2]),
                                rshift(CK[3]), rshift(CK[4]), rshift(CK[5])};

    // stage 1: wrap into [0, 360), quadrant, fold
    logic signed [MW-1:0]    m;
    logic [RW-1:0]           r;
    logic [1:0]              quad_next;
    logic [RW-1:0]           rem;
    logic [RW-1:0]           arg_next;
    logic                    swap_next;
    logic [1:0]              quad_reg;
    logic [RW-1:0]           arg_reg;
    logic                    swap_reg;

    always_comb begin
        m = MW'(angle);
        // angle is within a few turns: bounded corrections instead of a divider
        for (int i = 0; i < NWRAP; i++) begin
            if (m < 0) m = m + MW'(FULL);
        end
        for (int i = 0; i < NWRAP; i++) begin
            if (m >= MW'(FULL)) m = m - MW'(FULL);
        end
        r = RW'(m);
        if (r >= RW'(3*Q90)) begin
            quad_next = 2'd3; rem = r - RW'(3*Q90);
        end else if (r >= RW'(2*Q90)) begin
            quad_next = 2'd2; rem = r - RW'(2*Q90);
        end else if (r >= RW'(Q90)) begin
            quad_next = 2'd1; rem = r - RW'(Q90);
        end else begin
            quad_next = 2'd0; rem = r;
        end
        swap_next = ({1'b0, rem} << 1) > (RW+1)'(Q90);
        arg_next  = swap_next ? RW'(RW'(Q90) - rem) : rem;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quad_reg <= quad_next;
            arg_reg  <= arg_next;
            swap_reg <= swap_next;
        end
    end

    // stage 2: radians in Q30
    logic [63:0] xw;
    logic [31:0] x_reg;
    logic [1:0]  quad2_reg;
    logic        swap2_reg;
    assign xw = (64'(arg_reg) * 64'(DEG_TO_RAD_Q30)) >> ANGLE_FRAC_BITS;

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg     <= xw[31:0];
            quad2_reg <= quad_reg;
            swap2_reg <= swap_reg;
        end
    end

    // stage 3: x squared, then the series: two stages per Horner step,
    // product first, then divide by reciprocal multiply and subtract
    logic [63:0] x2w;
    logic [31:0] ts_reg  [NS+1];
    logic [31:0] tc_reg  [NS+1];
    logic [31:0] xs_reg  [NS+1];
    logic [31:0] x2s_reg [NS+1];
    logic [1:0]  qs_reg  [NS+1];
    logic        ws_reg  [NS+1];
    logic [31:0] ps_reg  [NS];
    logic [31:0] pc_reg  [NS];
    logic [31:0] xm_reg  [NS];
    logic [31:0] x2m_reg [NS];
    logic [1:0]  qm_reg  [NS];
    logic        wm_reg  [NS];
    logic [63:0] ps_w    [NS];
    logic [63:0] pc_w    [NS];
    logic [63:0] dqs_w   [NS];
    logic [63:0] dqc_w   [NS];
    assign x2w = 64'(x_reg) * 64'(x_reg);

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            ps_w[k]  = (64'(x2s_reg[k]) * 64'(ts_reg[k])) >> 30;
            pc_w[k]  = (64'(x2s_reg[k]) * 64'(tc_reg[k])) >> 30;
            dqs_w[k] = (64'(ps_reg[k]) * SM[k]) >> SSH[k];
            dqc_w[k] = (64'(pc_reg[k]) * CM[k]) >> CSH[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ts_reg[0]  <= 32'd1 << 30;
            tc_reg[0]  <= 32'd1 << 30;
            xs_reg[0]  <= x_reg;
            x2s_reg[0] <= 32'(x2w >> 30);
            qs_reg[0]  <= quad2_reg;
            ws_reg[0]  <= swap2_reg;
            for (int k = 0; k < NS; k++) begin
                ps_reg[k]    <= ps_w[k][31:0];
                pc_reg[k]    <= pc_w[k][31:0];
                xm_reg[k]    <= xs_reg[k];
                x2m_reg[k]   <= x2s_reg[k];
                qm_reg[k]    <= qs_reg[k];
                wm_reg[k]    <= ws_reg[k];
                ts_reg[k+1]  <= (32'd1 << 30) - dqs_w[k][31:0];
                tc_reg[k+1]  <= (32'd1 << 30) - dqc_w[k][31:0];
                xs_reg[k+1]  <= xm_reg[k];
                x2s_reg[k+1] <= x2m_reg[k];
                qs_reg[k+1]  <= qm_reg[k];
                ws_reg[k+1]  <= wm_reg[k];
            end
        end
    end

    // final: sine multiply, unfold, quadrant map
    logic [63:0]           sw;
    logic signed [Q_W-1:0] s0;
    logic signed [Q_W-1:0] c0;
    logic signed [Q_W-1:0] s1;
    logic signed [Q_W-1:0] c1;
    sc_t                   res_reg;
    assign sw = (64'(xs_reg[NS]) * 64'(ts_reg[NS])) >> 30;

    always_comb begin
        if (ws_reg[NS]) begin
            s0 = $signed(tc_reg[NS]);
            c0 = $signed(sw[31:0]);
        end else begin
            s0 = $signed(sw[31:0]);
            c0 = $signed(tc_reg[NS]);
        end
        unique case (qs_reg[NS])
            2'd1:    begin s1 = c0;  c1 = -s0; end
            2'd2:    begin s1 = -s0; c1 = -c0; end
            2'd3:    begin s1 = -c0; c1 = s0;  end
            default: begin s1 = s0;  c1 = c0;  end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg.s <= s1;
            res_reg.c <= c1;
        end
    end

    assign result = res_reg;
endmodule

@@ rtl/e2r_matrix.sv @@
// Matrix products and output rounding, three register stages.
module e2r_matrix
    import e2r_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic                   aclk,
    input  logic                   en,
    input  sc_t                    ang_a,
    input  sc_t                    ang_b,
    input  sc_t                    ang_c,
    output logic [9*OUT_W-1:0]     entries
);
    localparam int SH = 30 - OUT_FRAC_BITS;

    // stage 1: pair products
    logic signed [Q_W-1:0] cacc_reg, sasb_reg, ccsa_reg, casc_reg, cbsa_reg, cbsc_reg;
    logic signed [Q_W-1:0] cbcc_reg, casb_reg, sacc_reg, sasc_reg, cacb_reg, nsb_reg;
    logic signed [Q_W-1:0] sb1_reg, sc1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            cacc_reg <= qmul(ang_a.c, ang_c.c);
            sasb_reg <= qmul(ang_a.s, ang_b.s);
            ccsa_reg <= qmul(ang_c.c, ang_a.s);
            casc_reg <= qmul(ang_a.c, ang_c.s);
            cbsa_reg <= qmul(ang_b.c, ang_a.s);
            cbsc_reg <= qmul(ang_b.c, ang_c.s);
            cbcc_reg <= qmul(ang_b.c, ang_c.c);
            casb_reg <= qmul(ang_a.c, ang_b.s);
            sacc_reg <= qmul(ang_a.s, ang_c.c);
            sasc_reg <= qmul(ang_a.s, ang_c.s);
            cacb_reg <= qmul(ang_a.c, ang_b.c);
            nsb_reg  <= -ang_b.s;
            sb1_reg  <= ang_b.s;
            sc1_reg  <= ang_c.s;
        end
    end

    // stage 2: triple products and sums
    logic signed [Q_W:0] v_reg [9];

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg[0] <= (Q_W+1)'(cacc_reg) + (Q_W+1)'(qmul(sasb_reg, sc1_reg));
            v_reg[1] <= (Q_W+1)'(qmul(ccsa_reg, sb1_reg)) - (Q_W+1)'(casc_reg);
            v_reg[2] <= (Q_W+1)'(cbsa_reg);
            v_reg[3] <= (Q_W+1)'(cbsc_reg);
            v_reg[4] <= (Q_W+1)'(cbcc_reg);
            v_reg[5] <= (Q_W+1)'(nsb_reg);
            v_reg[6] <= (Q_W+1)'(qmul(casb_reg, sc1_reg)) - (Q_W+1)'(sacc_reg);
            v_reg[7] <= (Q_W+1)'(sasc_reg) + (Q_W+1)'(qmul(cacc_reg, sb1_reg));
            v_reg[8] <= (Q_W+1)'(cacb_reg);
        end
    end

    // stage 3: round half away from zero, saturate
    localparam logic [Q_W:0] LIM = (Q_W+1)'(1) << OUT_FRAC_BITS;

    logic [9*OUT_W-1:0] out_reg;
    logic [9*OUT_W-1:0] out_next;
    logic               neg;
    logic [Q_W:0]       mag;
    logic [Q_W:0]       rm;

    always_comb begin
        out_next = '0;
        for (int i = 0; i < 9; i++) begin
            neg = v_reg[i][Q_W];
            mag = neg ? (Q_W+1)'(-v_reg[i]) : (Q_W+1)'(v_reg[i]);
            if (SH > 0) rm = (mag + ((Q_W+1)'(1) << (SH - 1))) >> SH;
            else        rm = mag;
            if (rm > LIM) rm = LIM;
            out_next[i*OUT_W +: OUT_W] = neg ? OUT_W'(-rm) : OUT_W'(rm);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) out_reg <= out_next;
    end

    assign entries = out_reg;
endmodule

@@ rtl/euler_to_rotation_matrix_fixed.sv @@
// Euler angles to rotation matrix, fully pipelined, stream in and out.
// Throughput: one word per cycle; a stall freezes the whole pipeline.
// Stages: 3 reduction/radian/square, 12 series (6 steps of 2), 1 quadrant, 3 matrix.
// Reset: aresetn synchronous active low clears the stage valid bits only.
module euler_to_rotation_matrix_fixed
    import e2r_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 7,
    parameter int OUT_FRAC_BITS   = 14
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [55:0]   s_tdata,   // yaw_angle[16:0], pitch_angle[33:17], roll_angle[50:34]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [143:0]  m_tdata    // r00,r01,r02,r10,r11,r12,r20,r21,r22 16b each
);
    localparam int LAT = 19;

    logic [LAT-1:0] vld_reg;
    logic           en;

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    sc_t a_sc, b_sc, c_sc;

    e2r_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_yaw (
        .aclk(aclk), .en(en), .angle($signed(s_tdata[16:0])), .result(a_sc));
    e2r_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_roll (
        .aclk(aclk), .en(en), .angle($signed(s_tdata[50:34])), .result(b_sc));
    e2r_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_pitch (
        .aclk(aclk), .en(en), .angle($signed(s_tdata[33:17])), .result(c_sc));

    e2r_matrix #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_mat (
        .aclk(aclk), .en(en), .ang_a(a_sc), .ang_b(b_sc), .ang_c(c_sc),
        .entries(m_tdata));

    assign m_tvalid = vld_reg[LAT-1];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("pipeline stalled with empty output");
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted word not tracked");
endmodule
